>>> hdl/sha1_pkg.sv
// sha1_pkg: shared widths, constants, codes and control structs of the sha-1 engine
// no dependencies; compiled first

package sha1_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned WordW      = 32;
  localparam int unsigned LenW       = 64;
  localparam int unsigned NumWords   = 5;
  localparam int unsigned WinDepth   = 16;
  localparam int unsigned FillW      = 6;
  localparam int unsigned RoundW     = 7;

  // window taps for w[t-3], w[t-8], w[t-14], w[t-16] with w[0] the oldest word
  localparam int unsigned TapT3      = 13;
  localparam int unsigned TapT8      = 8;
  localparam int unsigned TapT14     = 2;
  localparam int unsigned TapT16     = 0;

  localparam logic [RoundW-1:0] MsgRounds   = 7'd16;
  localparam logic [RoundW-1:0] GroupEnd0   = 7'd20;
  localparam logic [RoundW-1:0] GroupEnd1   = 7'd40;
  localparam logic [RoundW-1:0] GroupEnd2   = 7'd60;
  localparam logic [RoundW-1:0] LastRound   = 7'd79;

  localparam logic [FillW-1:0]  LenPadPos   = 6'd56;
  localparam logic [ByteW-1:0]  PadByte     = 8'h80;
  localparam logic [LenW-1:0]   LenStep     = 64'd8;

  typedef logic [WordW-1:0] word_t;
  typedef logic [NumWords-1:0][WordW-1:0] chain_t;

  localparam chain_t ChainInit = {32'hc3d2e1f0, 32'h10325476, 32'h98badcfe,
                                  32'hefcdab89, 32'h67452301};

  typedef enum logic [1:0] {
    F_CH,
    F_PARITY_LO,
    F_MAJ,
    F_PARITY_HI
  } fsel_e;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_PAD  = 5'b00010,
    ST_COMP = 5'b00100,
    ST_FOLD = 5'b01000,
    ST_OUT  = 5'b10000
  } state_e;

  typedef struct packed {
    logic             push_byte;
    logic [ByteW-1:0] msg_byte;
    logic             push_word;
    logic             step;
    logic             expand;
  } sched_ctl_t;

  typedef struct packed {
    logic  load;
    logic  step;
    fsel_e fsel;
    logic  fold;
    logic  init;
  } core_ctl_t;

  function automatic word_t round_k(fsel_e sel);
    word_t k;
    case (sel)
      F_CH:        k = 32'h5a827999;
      F_PARITY_LO: k = 32'h6ed9eba1;
      F_MAJ:       k = 32'h8f1bbcdc;
      F_PARITY_HI: k = 32'hca62c1d6;
      default:     k = 32'h5a827999;
    endcase
    return k;
  endfunction

endpackage

>>> hdl/sha1_in_if.sv
// sha1_in_if: byte channel into the engine (valid/ready plus byte, byte flag, last flag)
// depends on sha1_pkg

interface sha1_in_if;
  import sha1_pkg::*;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] data_byte;
  logic             byte_valid;
  logic             last;

  modport source (output valid, data_byte, byte_valid, last, input ready);
  modport sink   (input valid, data_byte, byte_valid, last, output ready);
endinterface

>>> hdl/sha1_out_if.sv
// sha1_out_if: digest channel out of the engine (valid/ready plus five digest words)
// depends on sha1_pkg

interface sha1_out_if;
  import sha1_pkg::*;
  logic             valid;
  logic             ready;
  logic [WordW-1:0] digest_word0;
  logic [WordW-1:0] digest_word1;
  logic [WordW-1:0] digest_word2;
  logic [WordW-1:0] digest_word3;
  logic [WordW-1:0] digest_word4;

  modport source (output valid, digest_word0, digest_word1, digest_word2, digest_word3,
                  digest_word4, input ready);
  modport sink   (input valid, digest_word0, digest_word1, digest_word2, digest_word3,
                  digest_word4, output ready);
endinterface

>>> hdl/sha1_sched.sv
// sha1_sched: byte-to-word packer and 16-word message schedule shift window
// depends on sha1_pkg

module sha1_sched (
  input  logic                clk_i,
  input  sha1_pkg::sched_ctl_t ctl_i,
  output sha1_pkg::word_t     w_o
);
  import sha1_pkg::*;

  logic [WordW-ByteW-1:0] acc_q;
  word_t                  win_q [WinDepth];
  word_t                  mix;
  word_t                  w_cur;

  assign mix   = win_q[TapT3] ^ win_q[TapT8] ^ win_q[TapT14] ^ win_q[TapT16];
  // first 16 rounds recirculate the loaded message words
  assign w_cur = ctl_i.expand ? {mix[WordW-2:0], mix[WordW-1]} : win_q[0];
  assign w_o   = w_cur;

  always_ff @(posedge clk_i) begin
    if (ctl_i.push_byte) begin
      acc_q <= {acc_q[WordW-2*ByteW-1:0], ctl_i.msg_byte};
    end
    if (ctl_i.push_word || ctl_i.step) begin
      for (int i = 0; i < WinDepth - 1; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[WinDepth-1] <= ctl_i.step ? w_cur : {acc_q, ctl_i.msg_byte};
    end
  end

endmodule

>>> hdl/sha1_core.sv
// sha1_core: working registers a..e with the shared round adder, and the chaining words
// depends on sha1_pkg

module sha1_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sha1_pkg::core_ctl_t ctl_i,
  input  sha1_pkg::word_t     w_i,
  output sha1_pkg::chain_t    chain_o
);
  import sha1_pkg::*;

  chain_t chain_q, chain_d;
  chain_t work_q;
  word_t  a, b, c, d, e;
  word_t  f;
  word_t  tmp;

  assign a = work_q[0];
  assign b = work_q[1];
  assign c = work_q[2];
  assign d = work_q[3];
  assign e = work_q[4];

  always_comb begin
    case (ctl_i.fsel)
      F_CH:        f = (b & c) | (~b & d);
      F_PARITY_LO: f = b ^ c ^ d;
      F_MAJ:       f = (b & c) | (b & d) | (c & d);
      F_PARITY_HI: f = b ^ c ^ d;
      default:     f = b ^ c ^ d;
    endcase
  end

  assign tmp = {a[WordW-6:0], a[WordW-1:WordW-5]} + f + e + round_k(ctl_i.fsel) + w_i;

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      work_q <= chain_q;
    end else if (ctl_i.step) begin
      work_q[4] <= d;
      work_q[3] <= c;
      work_q[2] <= {b[1:0], b[WordW-1:2]};
      work_q[1] <= a;
      work_q[0] <= tmp;
    end
  end

  always_comb begin
    chain_d = chain_q;
    if (ctl_i.init) begin
      chain_d = ChainInit;
    end else if (ctl_i.fold) begin
      for (int i = 0; i < NumWords; i++) begin
        chain_d[i] = chain_q[i] + work_q[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q <= ChainInit;
    end else begin
      chain_q <= chain_d;
    end
  end

  assign chain_o = chain_q;

endmodule

>>> hdl/sha1_hash_engine.sv
// sha1_hash_engine: top level, sequencer for byte intake, padding, rounds and digest output
// depends on sha1_pkg, sha1_in_if, sha1_out_if, sha1_sched, sha1_core

// SHA-1 engine taking one message byte per transaction. A data byte is taken while the
// engine is idle; every 64th byte starts a compression that runs one round per cycle
// through a single shared round adder, 80 rounds and then a fold into the chaining
// words, during which the input is not ready. A transaction with last set starts padding,
// which feeds the 0x80 byte, zeros and the 8 length bytes through the same byte path at
// one per cycle while no block is being compressed; an extra block is compressed when
// fewer than 9 bytes of the block are free, and the block completed by the closing byte
// is compressed before padding when that byte itself completes a block. The digest moves
// into an output register as soon as that register is free and waits there until taken;
// meanwhile the engine restarts with the initial hash values and takes the next message,
// but a digest still waiting holds the next one back with the input not ready.

module sha1_hash_engine (
  input  logic  clk_i,
  input  logic  rst_ni,
  sha1_in_if.sink    in_i,
  sha1_out_if.source out_o
);
  import sha1_pkg::*;

  state_e            state_q, state_d;
  logic [FillW-1:0]  fill_q, fill_d;
  logic [LenW-1:0]   len_q, len_d;
  logic [RoundW-1:0] round_q, round_d;
  logic              pad_q, pad_d;
  logic              pad_first_q, pad_first_d;
  logic              len_mode_q, len_mode_d;
  logic              final_q, final_d;
  logic              out_valid_q, out_valid_d;
  chain_t            digest_q;

  logic              in_accept;
  logic              out_free;
  logic              pad_len;
  logic [ByteW-1:0]  pad_byte;
  logic              push_byte;
  logic              wrap;
  fsel_e             fsel;
  sched_ctl_t        sched_ctl;
  core_ctl_t         core_ctl;
  word_t             w;
  chain_t            chain;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_accept  = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;

  // length bytes start once the zero fill reaches byte 56 of the final block
  assign pad_len   = len_mode_q || ((fill_q == LenPadPos) && !pad_first_q);
  assign pad_byte  = pad_first_q ? PadByte : (pad_len ? len_q[LenW-1:LenW-ByteW] : '0);
  assign push_byte = (in_accept && in_i.byte_valid) || (state_q == ST_PAD);
  assign wrap      = push_byte && (&fill_q);

  always_comb begin
    if (round_q < GroupEnd0) begin
      fsel = F_CH;
    end else if (round_q < GroupEnd1) begin
      fsel = F_PARITY_LO;
    end else if (round_q < GroupEnd2) begin
      fsel = F_MAJ;
    end else begin
      fsel = F_PARITY_HI;
    end
  end

  always_comb begin
    sched_ctl.push_byte = push_byte;
    sched_ctl.msg_byte  = (state_q == ST_PAD) ? pad_byte : in_i.data_byte;
    sched_ctl.push_word = push_byte && (&fill_q[1:0]);
    sched_ctl.step      = (state_q == ST_COMP);
    sched_ctl.expand    = (round_q >= MsgRounds);
    core_ctl.load       = wrap;
    core_ctl.step       = (state_q == ST_COMP);
    core_ctl.fsel       = fsel;
    core_ctl.fold       = (state_q == ST_FOLD);
    core_ctl.init       = (state_q == ST_OUT) && out_free;
  end

  sha1_sched u_sched (
    .clk_i (clk_i),
    .ctl_i (sched_ctl),
    .w_o   (w)
  );

  sha1_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (core_ctl),
    .w_i     (w),
    .chain_o (chain)
  );

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    len_d       = len_q;
    round_d     = round_q;
    pad_d       = pad_q;
    pad_first_d = pad_first_q;
    len_mode_d  = len_mode_q;
    final_d     = final_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (in_i.byte_valid) begin
            len_d  = len_q + LenStep;
            fill_d = fill_q + 1'b1;
          end
          if (in_i.last) begin
            pad_d       = 1'b1;
            pad_first_d = 1'b1;
          end
          if (wrap) begin
            state_d = ST_COMP;
          end else if (in_i.last) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        fill_d      = fill_q + 1'b1;
        pad_first_d = 1'b0;
        if (pad_len) begin
          len_mode_d = 1'b1;
          len_d      = {len_q[LenW-ByteW-1:0], {ByteW{1'b0}}};
        end
        if (wrap) begin
          final_d = pad_len;
          state_d = ST_COMP;
        end
      end
      ST_COMP: begin
        if (round_q == LastRound) begin
          round_d = '0;
          state_d = ST_FOLD;
        end else begin
          round_d = round_q + 1'b1;
        end
      end
      ST_FOLD: begin
        if (final_q) begin
          state_d = ST_OUT;
        end else if (pad_q) begin
          state_d = ST_PAD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          len_d       = '0;
          pad_d       = 1'b0;
          len_mode_d  = 1'b0;
          final_d     = 1'b0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      len_q       <= '0;
      round_q     <= '0;
      pad_q       <= 1'b0;
      pad_first_q <= 1'b0;
      len_mode_q  <= 1'b0;
      final_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      len_q       <= len_d;
      round_q     <= round_d;
      pad_q       <= pad_d;
      pad_first_q <= pad_first_d;
      len_mode_q  <= len_mode_d;
      final_q     <= final_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_OUT) && out_free) begin
      digest_q <= chain;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.digest_word0 = digest_q[0];
  assign out_o.digest_word1 = digest_q[1];
  assign out_o.digest_word2 = digest_q[2];
  assign out_o.digest_word3 = digest_q[3];
  assign out_o.digest_word4 = digest_q[4];

endmodule

>>> hdl/sha1_checker.sv
// sha1_checker: port-level assertions for the sha-1 engine, bound to the top level
// depends on sha1_pkg and sha1_hash_engine

module sha1_checker (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_i,
  input logic                    in_last_i,
  input logic                    out_valid_i,
  input logic                    out_ready_i,
  input sha1_pkg::chain_t        digest_i
);
  import sha1_pkg::*;

  // a closing transaction starts padding or a compression, so no byte is taken in the next cycle
  a_last_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && in_last_i) |=> !in_ready_i)
    else $error("input ready right after closing transaction");

  // a new digest only appears after the input has been blocked
  a_digest_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_ready_i))
    else $error("digest appeared without a preceding busy cycle");

  // a waiting digest stays put until taken
  a_digest_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(digest_i)))
    else $error("digest dropped or changed while stalled");

  // an offered digest carries no unknown bits
  a_digest_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !$isunknown(digest_i))
    else $error("digest offered with unknown bits");

endmodule

bind sha1_hash_engine sha1_checker u_sha1_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_last_i   (in_i.last),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .digest_i    ({out_o.digest_word4, out_o.digest_word3, out_o.digest_word2,
                 out_o.digest_word1, out_o.digest_word0})
);
